/* hdl/rvx_pkg.sv */
package rvx_pkg;

	localparam int DataBytes = 4096;
	localparam int AddrW = $clog2(DataBytes);
	localparam int QDepth = 2;
	localparam int QPtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
	localparam int QCntW = $clog2(QDepth + 1);

	typedef enum logic [4:0] {
		K_ADD = 5'd0, K_SUB = 5'd1, K_SLL = 5'd2, K_SLT = 5'd3, K_SLTU = 5'd4,
		K_XOR = 5'd5, K_SRL = 5'd6, K_SRA = 5'd7, K_OR = 5'd8, K_AND = 5'd9,
		K_ADDI = 5'd10, K_SLTI = 5'd11, K_SRAI = 5'd12, K_LUI = 5'd13,
		K_AUIPC = 5'd14, K_LW = 5'd15, K_LBU = 5'd16, K_SW = 5'd17, K_SB = 5'd18,
		K_BEQ = 5'd19, K_BNE = 5'd20, K_BLT = 5'd21, K_JAL = 5'd22,
		K_JALR = 5'd23, K_LI = 5'd24
	} kind_t;

	// classified instruction handed from front to back
	typedef struct packed {
		logic [4:0]  kind;
		logic [4:0]  rd;
		logic [4:0]  rs1;
		logic [4:0]  rs2;
		logic [31:0] imm;
		logic [4:0]  shamt;
		logic        is_load;
		logic        is_store;
	} uop_t;

	typedef struct packed {
		logic [31:0] next_pc;
		logic        reg_written;
		logic [4:0]  written_index;
		logic [31:0] written_value;
		logic        mem_written;
		logic [31:0] mem_address;
		logic [31:0] mem_value;
	} res_t;

endpackage

/* hdl/rvx_front.sv */
// Accepts items, classifies them and holds them in a short queue for the back end.
module rvx_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic [4:0]    kind,
	input  logic [4:0]    dest_reg,
	input  logic [4:0]    src_reg_a,
	input  logic [4:0]    src_reg_b,
	input  logic [31:0]   immediate,
	input  logic [4:0]    shift_amount,
	output logic          uop_valid,
	output rvx_pkg::uop_t uop,
	input  logic          uop_take
);
	import rvx_pkg::*;

	uop_t             q_q [QDepth];
	logic [QPtrW-1:0] wp_q, rp_q;
	logic [QCntW-1:0] cnt_q;
	uop_t             nu;
	logic             acc;

	assign full = (cnt_q == QCntW'(QDepth));
	assign acc = push && !full;
	assign uop_valid = (cnt_q != '0);
	assign uop = q_q[rp_q];

	always_comb begin
		nu.kind = kind;
		nu.rd = dest_reg;
		nu.rs1 = src_reg_a;
		nu.rs2 = src_reg_b;
		nu.imm = immediate;
		nu.shamt = shift_amount;
		nu.is_load = (kind == K_LW) || (kind == K_LBU);
		nu.is_store = (kind == K_SW) || (kind == K_SB);
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			q_q[wp_q] <= nu;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (acc) wp_q <= (wp_q == QPtrW'(QDepth - 1)) ? '0 : wp_q + 1'b1;
			if (uop_take) rp_q <= (rp_q == QPtrW'(QDepth - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + QCntW'(acc) - QCntW'(uop_take);
		end
	end

endmodule

/* hdl/rvx_back.sv */
// Executes one uop in stages S1 and S2: S1 reads registers and memory, S2 writes back.
module rvx_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [31:0]   cfg_wdata,
	input  logic          uop_valid,
	input  rvx_pkg::uop_t uop,
	output logic          uop_take,
	output logic          res_valid,
	output rvx_pkg::res_t res,
	input  logic          res_take
);
	import rvx_pkg::*;

	logic [31:0] rf_q [32];
	logic [31:0] pc_q;
	logic [7:0]  mem0 [DataBytes/4];
	logic [7:0]  mem1 [DataBytes/4];
	logic [7:0]  mem2 [DataBytes/4];
	logic [7:0]  mem3 [DataBytes/4];

	logic        busy_s1;
	uop_t        u_s1;
	logic [31:0] a_s1, b_s1, ea_s1;
	logic [31:0] ld_s1;
	logic        out_full_q;
	res_t        res_q;

	logic [31:0] a, b, ea;
	logic [AddrW-1:0] ba [4];
	logic [AddrW-3:0] row [4];

	// S1 may start when idle and output slot will be free when S2 finishes
	assign uop_take = uop_valid && !busy_s1 && (!out_full_q || res_take);
	assign a = (uop.rs1 == 5'd0) ? 32'd0 : rf_q[uop.rs1];
	assign b = (uop.rs2 == 5'd0) ? 32'd0 : rf_q[uop.rs2];
	assign ea = a + uop.imm;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			ba[k] = ea[AddrW-1:0] + AddrW'(k);
			row[k] = ba[k][AddrW-1:2];
		end
	end

	// byte lanes: lane j holds bytes with address[1:0]==j; rows fetched per lane
	logic [AddrW-3:0] lrow [4];
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			lrow[j] = row[0];
			for (int k = 0; k < 4; k++) begin
				if (ba[k][1:0] == 2'(j)) lrow[j] = row[k];
			end
		end
	end

	logic [7:0] rd0_q, rd1_q, rd2_q, rd3_q;
	always_ff @(posedge clk) begin
		rd0_q <= mem0[lrow[0]];
		rd1_q <= mem1[lrow[1]];
		rd2_q <= mem2[lrow[2]];
		rd3_q <= mem3[lrow[3]];
	end

	logic [31:0] lanes;
	assign lanes = {rd3_q, rd2_q, rd1_q, rd0_q};
	always_comb begin
		ld_s1 = 32'd0;
		for (int k = 0; k < 4; k++) begin
			ld_s1[8*k +: 8] = lanes[8*(2'(ea_s1[1:0] + 2'(k))) +: 8];
		end
	end

	// execute
	logic        wr, mw;
	logic [31:0] val, npc, mval, maddr;
	logic [31:0] sum_ai, sum_pi;
	logic        slt_ab;
	always_comb begin
		sum_ai = a_s1 + u_s1.imm;
		sum_pi = pc_q + u_s1.imm;
		slt_ab = $signed(a_s1) < $signed(b_s1);
		wr = 1'b0;
		mw = 1'b0;
		val = 32'd0;
		mval = 32'd0;
		maddr = (u_s1.is_load || u_s1.is_store) ? ea_s1 : 32'd0;
		npc = pc_q + 32'd4;
		unique case (u_s1.kind)
			K_ADD:   begin wr = 1'b1; val = a_s1 + b_s1; end
			K_SUB:   begin wr = 1'b1; val = a_s1 - b_s1; end
			K_SLL:   begin wr = 1'b1; val = a_s1 << b_s1[4:0]; end
			K_SLT:   begin wr = 1'b1; val = {31'd0, slt_ab}; end
			K_SLTU:  begin wr = 1'b1; val = {31'd0, a_s1 < b_s1}; end
			K_XOR:   begin wr = 1'b1; val = a_s1 ^ b_s1; end
			K_SRL:   begin wr = 1'b1; val = a_s1 >> b_s1[4:0]; end
			K_SRA:   begin wr = 1'b1; val = 32'($signed(a_s1) >>> b_s1[4:0]); end
			K_OR:    begin wr = 1'b1; val = a_s1 | b_s1; end
			K_AND:   begin wr = 1'b1; val = a_s1 & b_s1; end
			K_ADDI:  begin wr = 1'b1; val = sum_ai; end
			K_SLTI:  begin wr = 1'b1; val = {31'd0, $signed(a_s1) < $signed(u_s1.imm)}; end
			K_SRAI:  begin wr = 1'b1; val = 32'($signed(a_s1) >>> u_s1.shamt); end
			K_LUI:   begin wr = 1'b1; val = u_s1.imm; end
			K_AUIPC: begin wr = 1'b1; val = sum_pi; end
			K_LW:    begin wr = 1'b1; val = ld_s1; end
			K_LBU:   begin wr = 1'b1; val = {24'd0, ld_s1[7:0]}; end
			K_SW:    begin mw = 1'b1; mval = b_s1; end
			K_SB:    begin mw = 1'b1; mval = {24'd0, b_s1[7:0]}; end
			K_BEQ:   if (a_s1 == b_s1) npc = sum_pi;
			K_BNE:   if (a_s1 != b_s1) npc = sum_pi;
			K_BLT:   if (slt_ab) npc = sum_pi;
			K_JAL:   begin wr = 1'b1; val = pc_q + 32'd4; npc = sum_pi; end
			K_JALR:  begin wr = 1'b1; val = pc_q + 32'd4; npc = sum_ai & ~32'd1; end
			K_LI:    begin wr = 1'b1; val = u_s1.imm; end
			default: ;
		endcase
		if (u_s1.rd == 5'd0) wr = 1'b0;
	end

	// store write: each lane gets at most one byte, so one write port per lane
	logic [AddrW-1:0] sba [4];
	logic [3:0]       lwe;
	logic [AddrW-3:0] wrow [4];
	logic [7:0]       wbyte [4];
	always_comb begin
		for (int k = 0; k < 4; k++) sba[k] = ea_s1[AddrW-1:0] + AddrW'(k);
		for (int j = 0; j < 4; j++) begin
			lwe[j] = 1'b0;
			wrow[j] = sba[0][AddrW-1:2];
			wbyte[j] = 8'd0;
			for (int k = 0; k < 4; k++) begin
				if ((k == 0 || u_s1.kind == K_SW) && sba[k][1:0] == 2'(j)) begin
					lwe[j] = busy_s1 && mw;
					wrow[j] = sba[k][AddrW-1:2];
					wbyte[j] = b_s1[8*k +: 8];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (lwe[0]) mem0[wrow[0]] <= wbyte[0];
		if (lwe[1]) mem1[wrow[1]] <= wbyte[1];
		if (lwe[2]) mem2[wrow[2]] <= wbyte[2];
		if (lwe[3]) mem3[wrow[3]] <= wbyte[3];
	end

	always_ff @(posedge clk) begin
		if (uop_take) begin
			u_s1 <= uop;
			a_s1 <= a;
			b_s1 <= b;
			ea_s1 <= ea;
		end
		if (busy_s1) begin
			res_q.next_pc <= npc;
			res_q.reg_written <= wr;
			res_q.written_index <= wr ? u_s1.rd : 5'd0;
			res_q.written_value <= wr ? val : 32'd0;
			res_q.mem_written <= mw;
			res_q.mem_address <= maddr;
			res_q.mem_value <= mval;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
			out_full_q <= 1'b0;
			pc_q <= 32'd0;
			for (int i = 0; i < 32; i++) rf_q[i] <= 32'd0;
		end else begin
			busy_s1 <= uop_take;
			if (busy_s1) out_full_q <= 1'b1;
			else if (res_take) out_full_q <= 1'b0;
			if (cfg_we) pc_q <= cfg_wdata;
			else if (busy_s1) pc_q <= npc;
			if (busy_s1 && wr) rf_q[u_s1.rd] <= val;
		end
	end

	assign res_valid = out_full_q;
	assign res = res_q;

endmodule

/* hdl/rv32i_subset_execute_core.sv */
// Channel  | Handshake          | Payload
// input    | push / full        | kind dest_reg src_reg_a src_reg_b immediate shift_amount
// result   | pop / empty        | next_pc reg_written written_index written_value
//          |                    | mem_written mem_address mem_value
// config   | start_we           | start_address (also loads the PC)
//
// In the back end each item first reads the register file and the banked
// data memory (registered read), then executes and writes back.
// A new item is taken only after the previous one has executed; results are registered.
// Reset clears registers and the PC to 0; data memory is not cleared.
// The front queue (2 entries) accepts until full while the result waits on pop.
module rv32i_subset_execute_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [4:0]  kind,
	input  logic [4:0]  dest_reg,
	input  logic [4:0]  src_reg_a,
	input  logic [4:0]  src_reg_b,
	input  logic [31:0] immediate,
	input  logic [4:0]  shift_amount,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] next_pc,
	output logic        reg_written,
	output logic [4:0]  written_index,
	output logic [31:0] written_value,
	output logic        mem_written,
	output logic [31:0] mem_address,
	output logic [31:0] mem_value,
	input  logic        start_we,
	input  logic [31:0] start_address
);
	import rvx_pkg::*;

	uop_t uop;
	res_t res;
	logic uop_valid, uop_take, res_valid;

	rvx_front u_front (
		.clk, .arst_n, .push, .full, .kind, .dest_reg, .src_reg_a, .src_reg_b,
		.immediate, .shift_amount, .uop_valid, .uop, .uop_take
	);

	rvx_back u_back (
		.clk, .arst_n, .cfg_we(start_we), .cfg_wdata(start_address),
		.uop_valid, .uop, .uop_take, .res_valid, .res, .res_take(pop && res_valid)
	);

	assign empty = !res_valid;
	assign next_pc = res.next_pc;
	assign reg_written = res.reg_written;
	assign written_index = res.written_index;
	assign written_value = res.written_value;
	assign mem_written = res.mem_written;
	assign mem_address = res.mem_address;
	assign mem_value = res.mem_value;

endmodule

/* hdl/rvx_checker.sv */
module rvx_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic        reg_written,
	input logic [4:0]  written_index,
	input logic [31:0] written_value,
	input logic        mem_written
);
	a_empty_reset: assert property (@(posedge clk) !arst_n |=> empty)
		else $error("result after reset");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(written_value)))
		else $error("result dropped");
	a_x0: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && reg_written) |-> (written_index != 5'd0))
		else $error("write to x0");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(reg_written && mem_written))
		else $error("both writes");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !reg_written) |-> (written_value == 32'd0 && written_index == 5'd0))
		else $error("stale write fields");
endmodule

bind rv32i_subset_execute_core rvx_checker u_rvx_checker (
	.clk, .arst_n, .empty, .pop, .reg_written, .written_index,
	.written_value, .mem_written
);

/* sim/rv32i_subset_execute_core_tb.sv */
module rv32i_subset_execute_core_tb;
	import rvx_pkg::*;

	localparam int MemBytes = 4096;
	localparam int CycleLimit = 400000;
	localparam int RandomItems = 500;	// per phase, four phases
	localparam logic [4:0] KindSpareLo = 5'd25;	// 25..31 do nothing but advance the PC
	localparam logic [4:0] KindSpareHi = 5'd31;

	typedef struct packed {
		logic [4:0]  kind;
		logic [4:0]  rd;
		logic [4:0]  rs1;
		logic [4:0]  rs2;
		logic [31:0] imm;
		logic [4:0]  shamt;
	} instr_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [4:0]  kind = '0;
	logic [4:0]  dest_reg = '0;
	logic [4:0]  src_reg_a = '0;
	logic [4:0]  src_reg_b = '0;
	logic [31:0] immediate = '0;
	logic [4:0]  shift_amount = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [31:0] next_pc;
	logic        reg_written;
	logic [4:0]  written_index;
	logic [31:0] written_value;
	logic        mem_written;
	logic [31:0] mem_address;
	logic [31:0] mem_value;
	logic        start_we = 1'b0;
	logic [31:0] start_address = '0;

	rv32i_subset_execute_core DUT (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// shadow machine state, advanced as items are queued (the block runs them in order)
	logic [31:0] shadow_regs [32];
	logic [31:0] shadow_pc;
	logic [7:0]  shadow_mem [MemBytes];
	bit          byte_valid [MemBytes];
	int          store_base [$];	// byte index of each store, for aiming loads
	int          store_len [$];

	instr_t pending_instrs [$];
	res_t   expected_results [$];
	int     fail_count = 0;
	int     cycle_count = 0;
	bit     idle_enabled = 1'b1;

	// execute one instruction on the shadow state and queue its result
	function automatic void queue_instr(instr_t it);
		res_t r;
		logic [31:0] a, b, v, ea;
		bit wr;
		int n;
		a = shadow_regs[it.rs1];
		b = shadow_regs[it.rs2];
		ea = a + it.imm;
		r = '0;
		r.next_pc = shadow_pc + 32'd4;
		wr = 1'b1;
		v = '0;
		n = 0;
		case (it.kind)
			K_ADD:   v = a + b;
			K_SUB:   v = a - b;
			K_SLL:   v = a << b[4:0];
			K_SLT:   v = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
			K_SLTU:  v = (a < b) ? 32'd1 : 32'd0;
			K_XOR:   v = a ^ b;
			K_SRL:   v = a >> b[4:0];
			K_SRA:   v = $signed(a) >>> b[4:0];
			K_OR:    v = a | b;
			K_AND:   v = a & b;
			K_ADDI:  v = a + it.imm;
			K_SLTI:  v = ($signed(a) < $signed(it.imm)) ? 32'd1 : 32'd0;
			K_SRAI:  v = $signed(a) >>> it.shamt;
			K_LUI, K_LI: v = it.imm;
			K_AUIPC: v = shadow_pc + it.imm;
			K_LW, K_LBU: begin
				r.mem_address = ea;
				n = (it.kind == K_LW) ? 4 : 1;
				for (int k = 0; k < n; k++)
					v |= 32'(shadow_mem[(ea % MemBytes + k) % MemBytes]) << (8 * k);
			end
			K_SW, K_SB: begin
				wr = 1'b0;
				n = (it.kind == K_SW) ? 4 : 1;
				r.mem_written = 1'b1;
				r.mem_address = ea;
				r.mem_value = (n == 4) ? b : {24'd0, b[7:0]};
				for (int k = 0; k < n; k++) begin
					shadow_mem[(ea % MemBytes + k) % MemBytes] = b[8*k +: 8];
					byte_valid[(ea % MemBytes + k) % MemBytes] = 1'b1;
				end
				store_base.push_back(ea % MemBytes);
				store_len.push_back(n);
			end
			K_BEQ: begin wr = 1'b0; if (a == b) r.next_pc = shadow_pc + it.imm; end
			K_BNE: begin wr = 1'b0; if (a != b) r.next_pc = shadow_pc + it.imm; end
			K_BLT: begin
				wr = 1'b0;
				if ($signed(a) < $signed(b)) r.next_pc = shadow_pc + it.imm;
			end
			K_JAL: begin v = shadow_pc + 32'd4; r.next_pc = shadow_pc + it.imm; end
			K_JALR: begin v = shadow_pc + 32'd4; r.next_pc = (a + it.imm) & ~32'd1; end
			default: wr = 1'b0;
		endcase
		if (it.rd == 5'd0) wr = 1'b0;
		if (wr) begin
			shadow_regs[it.rd] = v;
			r.reg_written = 1'b1;
			r.written_index = it.rd;
			r.written_value = v;
		end
		shadow_pc = r.next_pc;
		pending_instrs.push_back(it);
		expected_results.push_back(r);
	endfunction

	function automatic instr_t mk(logic [4:0] k, logic [4:0] rd, logic [4:0] rs1,
			logic [4:0] rs2, logic [31:0] imm, logic [4:0] sh);
		instr_t it;
		it = '{kind: k, rd: rd, rs1: rs1, rs2: rs2, imm: imm, shamt: sh};
		return it;
	endfunction

	// random instruction; loads are aimed only at bytes some store has written
	function automatic instr_t random_instr();
		instr_t it;
		int pick, sel, tgt;
		bit ok;
		it = mk(5'($urandom_range(0, 24)), 5'($urandom), 5'($urandom), 5'($urandom),
			$urandom, 5'($urandom));
		pick = $urandom_range(0, 99);
		if (pick < 12) it.kind = ($urandom_range(0, 1) != 0) ? K_LI : K_LUI;
		else if (pick < 20) it.kind = ($urandom_range(0, 1) != 0) ? K_SW : K_SB;
		else if (pick < 30) it.kind = ($urandom_range(0, 1) != 0) ? K_LW : K_LBU;
		else if (pick < 33) it.kind = 5'($urandom_range(KindSpareLo, KindSpareHi));
		if (pick < 12 && $urandom_range(0, 3) == 0)
			it.imm = ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'hFFFF_FFFF;
		if (it.kind == K_LW || it.kind == K_LBU) begin
			if (store_base.size() == 0) begin
				it.kind = K_SW;
			end else begin
				sel = $urandom_range(0, store_base.size() - 1);
				tgt = store_base[sel];
				if (store_len[sel] == 1) it.kind = K_LBU;
				else if (it.kind == K_LBU) tgt = (tgt + $urandom_range(0, 3)) % MemBytes;
				it.imm = 32'(tgt) + MemBytes * $urandom - shadow_regs[it.rs1];
				ok = 1'b1;
				for (int k = 0; k < ((it.kind == K_LW) ? 4 : 1); k++)
					if (!byte_valid[(tgt + k) % MemBytes]) ok = 1'b0;
				if (!ok) it.kind = K_LBU;
			end
		end
		return it;
	endfunction

	task automatic wait_idle();
		while (pending_instrs.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_start(logic [31:0] value);
		@(negedge clk);
		start_we <= 1'b1;
		start_address <= value;
		@(negedge clk);
		start_we <= 1'b0;
		shadow_pc = value;
	endtask

	// input side: item accepted at posedge when push && !full
	bit in_taken;
	int in_gap = 0;
	always @(posedge clk) in_taken = push && !full;

	always @(negedge clk) begin
		if (in_taken) begin
			void'(pending_instrs.pop_front());
			in_gap = idle_enabled ? $urandom_range(0, 4) : 0;
		end
		if (in_gap > 0) begin
			in_gap--;
			push <= 1'b0;
		end else if (pending_instrs.size() != 0) begin
			push <= 1'b1;
			kind <= pending_instrs[0].kind;
			dest_reg <= pending_instrs[0].rd;
			src_reg_a <= pending_instrs[0].rs1;
			src_reg_b <= pending_instrs[0].rs2;
			immediate <= pending_instrs[0].imm;
			shift_amount <= pending_instrs[0].shamt;
		end else begin
			push <= 1'b0;
		end
	end

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %h, got %h", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	// result side
	bit out_taken;
	int out_stall = 0;
	always @(posedge clk) begin
		cycle_count++;
		out_taken = pop && !empty;
		if (out_taken) begin
			if (expected_results.size() == 0) begin
				$error("result with no item outstanding");
				fail_count++;
			end else begin
				res_t e;
				e = expected_results.pop_front();
				check_field("next_pc", e.next_pc, next_pc);
				check_field("reg_written", 32'(e.reg_written), 32'(reg_written));
				check_field("written_index", 32'(e.written_index), 32'(written_index));
				check_field("written_value", e.written_value, written_value);
				check_field("mem_written", 32'(e.mem_written), 32'(mem_written));
				check_field("mem_address", e.mem_address, mem_address);
				check_field("mem_value", e.mem_value, mem_value);
			end
		end
		if (cycle_count > CycleLimit) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (out_taken) out_stall = idle_enabled ? $urandom_range(0, 4) : 0;
		if (out_stall > 0) begin
			out_stall--;
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	initial begin
		logic [31:0] starts [4];
		starts = '{32'hFFFF_FFFC, 32'hFFFF_FFFF, 32'h0, $urandom};
		foreach (shadow_regs[i]) shadow_regs[i] = '0;
		shadow_pc = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: extremes, every kind, x0 destination, wrap and misaligned access
		queue_instr(mk(K_LI,    5'd1, 5'd0, 5'd0, 32'h7FFF_FFFF, 5'd0));
		queue_instr(mk(K_LI,    5'd2, 5'd0, 5'd0, 32'h8000_0000, 5'd0));
		queue_instr(mk(K_LUI,   5'd3, 5'd0, 5'd0, 32'hFFFF_F000, 5'd0));
		queue_instr(mk(K_ADD,   5'd4, 5'd1, 5'd2, 32'd0, 5'd0));
		queue_instr(mk(K_SUB,   5'd5, 5'd2, 5'd1, 32'd0, 5'd0));
		queue_instr(mk(K_SLL,   5'd6, 5'd1, 5'd1, 32'd0, 5'd0));
		queue_instr(mk(K_SLT,   5'd7, 5'd2, 5'd1, 32'd0, 5'd0));
		queue_instr(mk(K_SLTU,  5'd8, 5'd2, 5'd1, 32'd0, 5'd0));
		queue_instr(mk(K_XOR,   5'd9, 5'd3, 5'd1, 32'd0, 5'd0));
		queue_instr(mk(K_SRL,   5'd10, 5'd2, 5'd1, 32'd0, 5'd0));
		queue_instr(mk(K_SRA,   5'd11, 5'd2, 5'd1, 32'd0, 5'd0));
		queue_instr(mk(K_OR,    5'd12, 5'd3, 5'd1, 32'd0, 5'd0));
		queue_instr(mk(K_AND,   5'd13, 5'd3, 5'd1, 32'd0, 5'd0));
		queue_instr(mk(K_ADDI,  5'd0, 5'd1, 5'd0, 32'h0000_0001, 5'd0));
		queue_instr(mk(K_SLTI,  5'd14, 5'd2, 5'd0, 32'hFFFF_FFFF, 5'd0));
		queue_instr(mk(K_SRAI,  5'd15, 5'd2, 5'd0, 32'd0, 5'd31));
		queue_instr(mk(K_AUIPC, 5'd16, 5'd0, 5'd0, 32'hFFFF_F000, 5'd0));
		queue_instr(mk(K_SW,    5'd0, 5'd0, 5'd1, 32'd4094, 5'd0));
		queue_instr(mk(K_LW,    5'd17, 5'd0, 5'd0, 32'hFFFF_FFFE, 5'd0));
		queue_instr(mk(K_SB,    5'd0, 5'd0, 5'd3, 32'd5, 5'd0));
		queue_instr(mk(K_LBU,   5'd18, 5'd0, 5'd0, 32'd5, 5'd0));
		queue_instr(mk(K_BEQ,   5'd0, 5'd0, 5'd0, 32'hFFFF_FFF0, 5'd0));
		queue_instr(mk(K_BNE,   5'd0, 5'd1, 5'd2, 32'h0000_0100, 5'd0));
		queue_instr(mk(K_BLT,   5'd0, 5'd2, 5'd1, 32'h7FFF_FFFC, 5'd0));
		queue_instr(mk(K_JAL,   5'd19, 5'd0, 5'd0, 32'hFFFF_FFF8, 5'd0));
		queue_instr(mk(K_JALR,  5'd20, 5'd1, 5'd0, 32'd3, 5'd0));
		queue_instr(mk(KindSpareHi, 5'd21, 5'd1, 5'd2, 32'hFFFF_FFFF, 5'd31));
		wait_idle();

		// random phases, each with its own start address; one phase without idling
		for (int p = 0; p < 4; p++) begin
			write_start(starts[p]);
			idle_enabled = (p != 2);
			for (int i = 0; i < RandomItems; i++) queue_instr(random_instr());
			wait_idle();
		end

		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
